### hdl/maneuver_sequencer_with_obstacle_hold_core_macros.svh
// ---------------------------------------------------------------------------
// Maneuver sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef MANEUVER_SEQUENCER_WITH_OBSTACLE_HOLD_CORE_MACROS_SVH
`define MANEUVER_SEQUENCER_WITH_OBSTACLE_HOLD_CORE_MACROS_SVH

// same-cycle implication
`define MSOH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSOH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/msoh_pkg.sv
// ---------------------------------------------------------------------------
// Maneuver sequencer package
// Phase, drive and steering codes, register indexes and reset values.
// ---------------------------------------------------------------------------
package msoh_pkg;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_LONG_FWD     = 4'd1,
    PH_PAUSE_A      = 4'd2,
    PH_STEER_LEFT   = 4'd3,
    PH_LEFT_TURN    = 4'd4,
    PH_PAUSE_B      = 4'd5,
    PH_STEER_RIGHT  = 4'd6,
    PH_RIGHT_TURN   = 4'd7,
    PH_PAUSE_C      = 4'd8,
    PH_STEER_CENTRE = 4'd9,
    PH_PAUSE_D      = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_FWD  = 2'd1,
    DRV_REV  = 2'd2
  } drive_e;

  typedef enum logic [1:0] {
    STR_CENTRE = 2'd0,
    STR_LEFT   = 2'd1,
    STR_RIGHT  = 2'd2
  } steer_e;

  typedef enum logic [2:0] {
    CFG_FRONT_THRESH = 3'd0,
    CFG_REAR_THRESH  = 3'd1,
    CFG_RESUME_DELAY = 3'd2,
    CFG_AUTO_SPEED   = 3'd3,
    CFG_LONG_FWD     = 3'd4,
    CFG_LEFT_TURN    = 3'd5,
    CFG_RIGHT_TURN   = 3'd6,
    CFG_PAUSE        = 3'd7
  } cfg_idx_e;

  localparam logic [9:0]  RstFrontThresh = 10'd30;
  localparam logic [9:0]  RstRearThresh  = 10'd30;
  localparam logic [15:0] RstResumeDelay = 16'd3000;
  localparam logic [7:0]  RstAutoSpeed   = 8'd170;
  localparam logic [15:0] RstLongFwd     = 16'd1200;
  localparam logic [15:0] RstLeftTurn    = 16'd1000;
  localparam logic [15:0] RstRightTurn   = 16'd1200;
  localparam logic [15:0] RstPause       = 16'd1000;

  typedef struct packed {
    logic        autonomous_on;
    logic        stop_request;
    logic        yield_request;
    logic [31:0] encoder_count;
    logic [9:0]  front_distance_cm;
    logic [9:0]  rear_distance_cm;
    logic [31:0] now_ms;
    logic [7:0]  current_speed;
  } in_item_t;

  typedef struct packed {
    drive_e     motor_drive;
    steer_e     steer_position;
    logic [7:0] speed_out;
    phase_e     phase_out;
    logic       front_blocked;
    logic       rear_blocked;
  } out_item_t;

endpackage

### hdl/maneuver_sequencer_with_obstacle_hold_core.sv
// Path: an accepted transaction passes from the input register to the result register.
// Throughput: one transaction per cycle while out_stall_i does not hold the result; the
// sequencer state, input register and result register all advance in the same cycle.
// Reset: asynchronous, active low; phase idle, drive stopped, steering centred,
// holds and timers cleared, registers back to their default values.
// ---------------------------------------------------------------------------
// Maneuver sequencer with obstacle hold
// Looping autonomous maneuver with stop hold and front/rear obstacle holds.
// ---------------------------------------------------------------------------
`include "maneuver_sequencer_with_obstacle_hold_core_macros.svh"

module maneuver_sequencer_with_obstacle_hold_core
  import msoh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        autonomous_on_i,
  input  logic        stop_request_i,
  input  logic        yield_request_i,
  input  logic [31:0] encoder_count_i,
  input  logic [9:0]  front_distance_cm_i,
  input  logic [9:0]  rear_distance_cm_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  current_speed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  motor_drive_o,
  output logic [1:0]  steer_position_o,
  output logic [7:0]  speed_out_o,
  output logic [3:0]  phase_out_o,
  output logic        front_blocked_o,
  output logic        rear_blocked_o
);

  logic [9:0]  front_thr_q, rear_thr_q;
  logic [15:0] resume_q, long_fwd_q, left_turn_q, right_turn_q, pause_q;
  logic [7:0]  auto_speed_q;

  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q, out_d;
  logic      out_valid_q;
  logic      advance;

  phase_e      phase_q, phase_d;
  drive_e      drive_q, drive_d;
  steer_e      steer_q, steer_d;
  logic [31:0] start_cnt_q, start_cnt_d;
  logic [31:0] phase_t_q, phase_t_d;
  logic        f_hold_q, f_hold_d, r_hold_q, r_hold_d;
  logic [31:0] f_clr_t_q, f_clr_t_d, r_clr_t_q, r_clr_t_d;
  logic        f_armed_q, f_armed_d, r_armed_q, r_armed_d;
  logic [7:0]  saved_q, saved_d;
  logic        saved_vld_q, saved_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_thr_q  <= RstFrontThresh;
      rear_thr_q   <= RstRearThresh;
      resume_q     <= RstResumeDelay;
      auto_speed_q <= RstAutoSpeed;
      long_fwd_q   <= RstLongFwd;
      left_turn_q  <= RstLeftTurn;
      right_turn_q <= RstRightTurn;
      pause_q      <= RstPause;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FRONT_THRESH: front_thr_q  <= cfg_wdata_i[9:0];
        CFG_REAR_THRESH:  rear_thr_q   <= cfg_wdata_i[9:0];
        CFG_RESUME_DELAY: resume_q     <= cfg_wdata_i;
        CFG_AUTO_SPEED:   auto_speed_q <= cfg_wdata_i[7:0];
        CFG_LONG_FWD:     long_fwd_q   <= cfg_wdata_i;
        CFG_LEFT_TURN:    left_turn_q  <= cfg_wdata_i;
        CFG_RIGHT_TURN:   right_turn_q <= cfg_wdata_i;
        CFG_PAUSE:        pause_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= '{autonomous_on:     autonomous_on_i,
                stop_request:      stop_request_i,
                yield_request:     yield_request_i,
                encoder_count:     encoder_count_i,
                front_distance_cm: front_distance_cm_i,
                rear_distance_cm:  rear_distance_cm_i,
                now_ms:            now_ms_i,
                current_speed:     current_speed_i};
    end
  end

  always_comb begin
    logic        done;
    logic        rear_near, front_near, front_moving;
    logic [7:0]  spd;
    logic [31:0] now, enc, eff, elapsed, ahead, back, since;
    logic        timed_out, ahead_long, ahead_left, back_right;

    phase_d     = phase_q;
    drive_d     = drive_q;
    steer_d     = steer_q;
    start_cnt_d = start_cnt_q;
    phase_t_d   = phase_t_q;
    f_hold_d    = f_hold_q;
    r_hold_d    = r_hold_q;
    f_clr_t_d   = f_clr_t_q;
    r_clr_t_d   = r_clr_t_q;
    f_armed_d   = f_armed_q;
    r_armed_d   = r_armed_q;
    saved_d     = saved_q;
    saved_vld_d = saved_vld_q;

    done = 1'b0;
    now  = in_q.now_ms;
    enc  = in_q.encoder_count;
    spd  = in_q.current_speed;

    rear_near    = (in_q.rear_distance_cm != '0) && (in_q.rear_distance_cm < rear_thr_q);
    front_near   = (in_q.front_distance_cm != '0) && (in_q.front_distance_cm < front_thr_q);
    front_moving = (phase_q == PH_LONG_FWD) || (phase_q == PH_LEFT_TURN);

    since      = now - phase_t_q;
    timed_out  = since >= {16'b0, pause_q};
    ahead      = enc - start_cnt_q;
    back       = start_cnt_q - enc;
    ahead_long = !ahead[31] && (ahead >= {16'b0, long_fwd_q});
    ahead_left = !ahead[31] && (ahead >= {16'b0, left_turn_q});
    back_right = !back[31] && (back >= {16'b0, right_turn_q});
    eff        = '0;
    elapsed    = '0;

    if (!saved_vld_q) begin
      saved_d     = in_q.current_speed;
      saved_vld_d = 1'b1;
    end

    if (!in_q.autonomous_on) begin
      spd = saved_d;
      if (phase_q != PH_IDLE) begin
        drive_d = DRV_STOP;
        phase_d = PH_IDLE;
      end
      done = 1'b1;
    end else if (in_q.stop_request) begin
      drive_d = DRV_STOP;
      done    = 1'b1;
    end else if ((phase_q == PH_RIGHT_TURN) && rear_near) begin
      if (!r_hold_q) begin
        r_hold_d = 1'b1;
        drive_d  = DRV_STOP;
      end
      done = 1'b1;
    end else if (front_moving && front_near) begin
      if (!f_hold_q) begin
        f_hold_d = 1'b1;
        drive_d  = DRV_STOP;
      end
      done = 1'b1;
    end

    if (!done && r_hold_q) begin
      if (rear_near) begin
        done = 1'b1;
      end else begin
        eff       = r_armed_q ? r_clr_t_q : now;
        elapsed   = now - eff;
        r_clr_t_d = eff;
        r_armed_d = 1'b1;
        if (elapsed < {16'b0, resume_q}) begin
          done = 1'b1;
        end else begin
          r_hold_d  = 1'b0;
          r_armed_d = 1'b0;
          r_clr_t_d = '0;
          if (phase_q == PH_RIGHT_TURN) drive_d = DRV_REV;
        end
      end
    end

    if (!done && f_hold_q) begin
      if (front_near) begin
        done = 1'b1;
      end else begin
        eff       = f_armed_q ? f_clr_t_q : now;
        elapsed   = now - eff;
        f_clr_t_d = eff;
        f_armed_d = 1'b1;
        if (elapsed < {16'b0, resume_q}) begin
          done = 1'b1;
        end else begin
          f_hold_d  = 1'b0;
          f_armed_d = 1'b0;
          f_clr_t_d = '0;
          if (front_moving) drive_d = DRV_FWD;
        end
      end
    end

    if (!done) begin
      if (!in_q.yield_request && (spd != auto_speed_q)) begin
        saved_d = spd;
        spd     = auto_speed_q;
      end
      unique case (phase_q)
        PH_IDLE: begin
          steer_d     = STR_CENTRE;
          start_cnt_d = enc;
          drive_d     = DRV_FWD;
          phase_d     = PH_LONG_FWD;
        end
        PH_LONG_FWD: begin
          if (ahead_long) begin
            drive_d   = DRV_STOP;
            phase_t_d = now;
            phase_d   = PH_PAUSE_A;
          end
        end
        PH_PAUSE_A: begin
          if (timed_out) begin
            steer_d   = STR_LEFT;
            phase_t_d = now;
            phase_d   = PH_STEER_LEFT;
          end
        end
        PH_STEER_LEFT: begin
          if (timed_out) begin
            start_cnt_d = enc;
            drive_d     = DRV_FWD;
            phase_d     = PH_LEFT_TURN;
          end
        end
        PH_LEFT_TURN: begin
          if (ahead_left) begin
            drive_d   = DRV_STOP;
            phase_t_d = now;
            phase_d   = PH_PAUSE_B;
          end
        end
        PH_PAUSE_B: begin
          if (timed_out) begin
            steer_d   = STR_RIGHT;
            phase_t_d = now;
            phase_d   = PH_STEER_RIGHT;
          end
        end
        PH_STEER_RIGHT: begin
          if (timed_out) begin
            start_cnt_d = enc;
            drive_d     = DRV_REV;
            phase_d     = PH_RIGHT_TURN;
          end
        end
        PH_RIGHT_TURN: begin
          if (back_right) begin
            drive_d   = DRV_STOP;
            phase_t_d = now;
            phase_d   = PH_PAUSE_C;
          end
        end
        PH_PAUSE_C: begin
          if (timed_out) begin
            steer_d   = STR_CENTRE;
            phase_t_d = now;
            phase_d   = PH_STEER_CENTRE;
          end
        end
        PH_STEER_CENTRE: begin
          if (timed_out) begin
            phase_t_d = now;
            phase_d   = PH_PAUSE_D;
          end
        end
        PH_PAUSE_D: begin
          if (timed_out) begin
            start_cnt_d = enc;
            drive_d     = DRV_FWD;
            phase_d     = PH_LONG_FWD;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end

    out_d = '{motor_drive:    drive_d,
              steer_position: steer_d,
              speed_out:      spd,
              phase_out:      phase_d,
              front_blocked:  f_hold_d,
              rear_blocked:   r_hold_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      drive_q     <= DRV_STOP;
      steer_q     <= STR_CENTRE;
      start_cnt_q <= '0;
      phase_t_q   <= '0;
      f_hold_q    <= 1'b0;
      r_hold_q    <= 1'b0;
      f_clr_t_q   <= '0;
      r_clr_t_q   <= '0;
      f_armed_q   <= 1'b0;
      r_armed_q   <= 1'b0;
      saved_q     <= '0;
      saved_vld_q <= 1'b0;
    end else if (advance) begin
      phase_q     <= phase_d;
      drive_q     <= drive_d;
      steer_q     <= steer_d;
      start_cnt_q <= start_cnt_d;
      phase_t_q   <= phase_t_d;
      f_hold_q    <= f_hold_d;
      r_hold_q    <= r_hold_d;
      f_clr_t_q   <= f_clr_t_d;
      r_clr_t_q   <= r_clr_t_d;
      f_armed_q   <= f_armed_d;
      r_armed_q   <= r_armed_d;
      saved_q     <= saved_d;
      saved_vld_q <= saved_vld_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign motor_drive_o    = out_q.motor_drive;
  assign steer_position_o = out_q.steer_position;
  assign speed_out_o      = out_q.speed_out;
  assign phase_out_o      = out_q.phase_out;
  assign front_blocked_o  = out_q.front_blocked;
  assign rear_blocked_o   = out_q.rear_blocked;

  `MSOH_ASSERT_NEXT(a_manual_idles, advance && !in_q.autonomous_on,
                    out_q.phase_out == PH_IDLE, "manual transaction left phase active")
  `MSOH_ASSERT_NOW(a_rev_in_rturn, out_valid_q && (out_q.motor_drive == DRV_REV),
                   out_q.phase_out == PH_RIGHT_TURN, "reverse drive outside right turn")
  `MSOH_ASSERT_NOW(a_fwd_in_fphase, out_valid_q && (out_q.motor_drive == DRV_FWD),
                   (out_q.phase_out == PH_LONG_FWD) || (out_q.phase_out == PH_LEFT_TURN),
                   "forward drive outside a forward phase")

endmodule
